// ===== src/plc_pkg.sv =====
// ============================================================================
// plc_pkg
// Shared constants and types for the parametric line clipper.
// ============================================================================
package plc_pkg;

    // default widths
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // one lane per window edge: left, right, bottom, top
    localparam int NUM_EDGES = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP    = 3'd3;

    // per-edge classification travelling beside the dividers
    typedef struct packed {
        logic [NUM_EDGES-1:0] use_exit;   // p > 0, q >= 0: bounds t1
        logic [NUM_EDGES-1:0] use_entry;  // p < 0, q < 0: bounds t0
        logic                 reject;     // some edge rejects outright
    } edge_flags_t;

endpackage

// ===== src/plc_edge_setup.sv =====
// ============================================================================
// plc_edge_setup
// First stage: deltas, the four (p, q) edge terms and their classification.
// ============================================================================
module plc_edge_setup #(
    parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          adv,
    input  logic                                          in_valid,
    input  logic [COORD_BITS-1:0]                         start_x,
    input  logic [COORD_BITS-1:0]                         start_y,
    input  logic [COORD_BITS-1:0]                         end_x,
    input  logic [COORD_BITS-1:0]                         end_y,
    input  logic [COORD_BITS-1:0]                         window_left,
    input  logic [COORD_BITS-1:0]                         window_right,
    input  logic [COORD_BITS-1:0]                         window_bottom,
    input  logic [COORD_BITS-1:0]                         window_top,
    output logic                                          out_valid,
    output logic [plc_pkg::NUM_EDGES-1:0][COORD_BITS-1:0] p_mag,
    output logic [plc_pkg::NUM_EDGES-1:0][COORD_BITS-1:0] q_mag,
    output plc_pkg::edge_flags_t                          flags,
    output logic [COORD_BITS-1:0]                         sx,
    output logic [COORD_BITS-1:0]                         sy,
    output logic signed [COORD_BITS:0]                    dx,
    output logic signed [COORD_BITS:0]                    dy
);

    localparam int C = COORD_BITS;
    localparam int E = plc_pkg::NUM_EDGES;

    logic signed [C:0]    dx_c, dy_c;
    logic signed [C:0]    p_c [E];
    logic signed [C:0]    q_c [E];
    logic [E-1:0][C-1:0]  p_mag_next, q_mag_next;
    plc_pkg::edge_flags_t flags_next;

    logic                 valid_reg;
    logic [E-1:0][C-1:0]  p_mag_reg, q_mag_reg;
    plc_pkg::edge_flags_t flags_reg;
    logic [C-1:0]         sx_reg, sy_reg;
    logic signed [C:0]    dx_reg, dy_reg;

    // edge terms and their classes
    always_comb begin
        dx_c   = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
        dy_c   = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
        p_c[0] = -dx_c;
        q_c[0] = $signed({1'b0, start_x}) - $signed({1'b0, window_left});
        p_c[1] = dx_c;
        q_c[1] = $signed({1'b0, window_right}) - $signed({1'b0, start_x});
        p_c[2] = -dy_c;
        q_c[2] = $signed({1'b0, start_y}) - $signed({1'b0, window_bottom});
        p_c[3] = dy_c;
        q_c[3] = $signed({1'b0, window_top}) - $signed({1'b0, start_y});
        flags_next = '0;
        for (int l = 0; l < E; l++) begin
            p_mag_next[l] = p_c[l][C] ? C'(-p_c[l]) : p_c[l][C-1:0];
            q_mag_next[l] = q_c[l][C] ? C'(-q_c[l]) : q_c[l][C-1:0];
            flags_next.use_entry[l] = p_c[l][C] && q_c[l][C];
            flags_next.use_exit[l]  = !p_c[l][C] && (p_c[l] != '0) && !q_c[l][C];
            if (q_c[l][C] && !p_c[l][C]) begin
                flags_next.reject = 1'b1;
            end
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            p_mag_reg <= p_mag_next;
            q_mag_reg <= q_mag_next;
            flags_reg <= flags_next;
            sx_reg    <= start_x;
            sy_reg    <= start_y;
            dx_reg    <= dx_c;
            dy_reg    <= dy_c;
        end
    end

    assign out_valid = valid_reg;
    assign p_mag     = p_mag_reg;
    assign q_mag     = q_mag_reg;
    assign flags     = flags_reg;
    assign sx        = sx_reg;
    assign sy        = sy_reg;
    assign dx        = dx_reg;
    assign dy        = dy_reg;

endmodule

// ===== src/plc_div_pipe.sv =====
// ============================================================================
// plc_div_pipe
// Four-lane pipelined restoring divider, one quotient bit per stage, giving
// floor(num * 2^FRAC_BITS / den) for num <= den, with an overflow flag.
// ============================================================================
module plc_div_pipe #(
    parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = plc_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W     = 1
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          adv,
    input  logic                                          in_valid,
    input  logic [plc_pkg::NUM_EDGES-1:0][COORD_BITS-1:0] in_num,
    input  logic [plc_pkg::NUM_EDGES-1:0][COORD_BITS-1:0] in_den,
    input  logic [SIDE_W-1:0]                             in_side,
    output logic                                          out_valid,
    output logic [plc_pkg::NUM_EDGES-1:0][FRAC_BITS:0]    out_quo,
    output logic [plc_pkg::NUM_EDGES-1:0]                 out_over,
    output logic [SIDE_W-1:0]                             out_side
);

    localparam int C = COORD_BITS;
    localparam int F = FRAC_BITS;
    localparam int E = plc_pkg::NUM_EDGES;
    localparam int S = F + 1;

    logic                vld_reg  [S];
    logic [E-1:0]        over_reg [S];
    logic [SIDE_W-1:0]   side_reg [S];
    logic [E-1:0][F:0]   quo_reg  [S];
    logic [E-1:0][C-1:0] rem_reg  [S-1];
    logic [E-1:0][C-1:0] den_reg  [S-1];

    logic [E-1:0][C:0]   cand     [S];
    logic [E-1:0][C-1:0] den_src  [S];
    logic [E-1:0][F:0]   quo_src  [S];
    logic [E-1:0]        ge       [S];
    logic [E-1:0][F:0]   quo_next [S];
    logic [E-1:0][C-1:0] rem_next [S-1];
    logic [E-1:0]        over_in;

    // stage inputs, one trial subtraction per stage and lane
    always_comb begin
        for (int l = 0; l < E; l++) begin
            over_in[l] = in_num[l] > in_den[l];
            cand[0][l] = {1'b0, in_num[l]};
        end
        den_src[0] = in_den;
        quo_src[0] = '0;
        for (int s = 1; s < S; s++) begin
            for (int l = 0; l < E; l++) begin
                cand[s][l] = {rem_reg[s-1][l], 1'b0};
            end
            den_src[s] = den_reg[s-1];
            quo_src[s] = quo_reg[s-1];
        end
        for (int s = 0; s < S; s++) begin
            for (int l = 0; l < E; l++) begin
                ge[s][l]             = cand[s][l] >= {1'b0, den_src[s][l]};
                quo_next[s][l]       = quo_src[s][l];
                quo_next[s][l][F-s]  = ge[s][l];
            end
        end
        for (int s = 0; s < S - 1; s++) begin
            for (int l = 0; l < E; l++) begin
                rem_next[s][l] = ge[s][l] ? C'(cand[s][l] - {1'b0, den_src[s][l]})
                                          : cand[s][l][C-1:0];
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < S; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < S; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            over_reg[0] <= over_in;
            side_reg[0] <= in_side;
            for (int s = 1; s < S; s++) begin
                over_reg[s] <= over_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
            for (int s = 0; s < S; s++) begin
                quo_reg[s] <= quo_next[s];
            end
            for (int s = 0; s < S - 1; s++) begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_src[s];
            end
        end
    end

    assign out_valid = vld_reg[S-1];
    assign out_quo   = quo_reg[S-1];
    assign out_over  = over_reg[S-1];
    assign out_side  = side_reg[S-1];

endmodule

// ===== src/plc_point.sv =====
// ============================================================================
// plc_point
// Two stages: products |d| * t, then rounding and offset from the start point.
// ============================================================================
module plc_point #(
    parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = plc_pkg::FRAC_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          adv,
    input  logic                                          in_valid,
    input  logic                                          in_ok,
    input  logic [FRAC_BITS:0]                            t0,
    input  logic [FRAC_BITS:0]                            t1,
    input  logic [COORD_BITS-1:0]                         sx,
    input  logic [COORD_BITS-1:0]                         sy,
    input  logic signed [COORD_BITS:0]                    dx,
    input  logic signed [COORD_BITS:0]                    dy,
    output logic                                          out_valid,
    output logic                                          out_visible,
    output logic [plc_pkg::NUM_EDGES-1:0][COORD_BITS-1:0] out_coord
);

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int E  = plc_pkg::NUM_EDGES;
    localparam int PW = C + F + 1;
    localparam int SW = PW + 1;
    localparam logic [SW-1:0] HALF = SW'(1) << (F - 1);

    logic [C-1:0]         mag_x, mag_y;
    logic [E-1:0][PW-1:0] prod_next;

    logic                 va_reg, vb_reg;
    logic                 ok_reg, vis_reg;
    logic [E-1:0][PW-1:0] prod_reg;
    logic [1:0]           neg_reg;
    logic [C-1:0]         sx_reg, sy_reg;
    logic [E-1:0][C-1:0]  coord_reg;

    logic [E-1:0][C-1:0]  coord_next;
    logic [SW-1:0]        sum;
    logic [C-1:0]         offm, base;
    logic                 neg;

    // products: start x, start y at t0, end x, end y at t1
    always_comb begin
        mag_x = dx[C] ? C'(-dx) : dx[C-1:0];
        mag_y = dy[C] ? C'(-dy) : dy[C-1:0];
        prod_next[0] = PW'(mag_x * t0);
        prod_next[1] = PW'(mag_y * t0);
        prod_next[2] = PW'(mag_x * t1);
        prod_next[3] = PW'(mag_y * t1);
    end

    // round to nearest, ties upward, and step from the start point
    always_comb begin
        coord_next = '0;
        sum  = '0;
        offm = '0;
        base = '0;
        neg  = 1'b0;
        for (int k = 0; k < E; k++) begin
            neg  = (k % 2 == 0) ? neg_reg[0] : neg_reg[1];
            base = (k % 2 == 0) ? sx_reg : sy_reg;
            sum  = neg ? ({1'b0, prod_reg[k]} + HALF - SW'(1))
                       : ({1'b0, prod_reg[k]} + HALF);
            offm = sum[F +: C];
            if (ok_reg) begin
                coord_next[k] = neg ? base - offm : base + offm;
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg  <= prod_next;
            neg_reg   <= {dy[C], dx[C]};
            sx_reg    <= sx;
            sy_reg    <= sy;
            ok_reg    <= in_ok;
            coord_reg <= coord_next;
            vis_reg   <= ok_reg;
        end
    end

    assign out_valid   = vb_reg;
    assign out_visible = vis_reg;
    assign out_coord   = coord_reg;

endmodule

// ===== src/parametric_line_clipper.sv =====
// ============================================================================
// parametric_line_clipper
// Liang-Barsky clipping of one segment per item against a configured window.
// ============================================================================
//  channel | ports                          | item
//  --------+--------------------------------+-----------------------------------
//  in      | s_tvalid s_tready s_tdata      | start_x start_y end_x end_y
//  out     | m_tvalid m_tready m_tdata/user | visible, clipped start and end
//  config  | cfg_valid cfg_ready cfg_index  | window register write
//          | cfg_data                       |
//
//  one item a cycle while s_tready is high; the divider pipeline computes
//  one quotient bit per stage
//  aresetn clears valid bits and loads the full-range window
//  all stages advance together; an output register and a skid register
//  take the result, and s_tready is low only while the skid register is full
// ============================================================================
module parametric_line_clipper #(
    parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = plc_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x, start_y, end_x, end_y
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // visible
    output logic                          m_tuser,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [plc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]         cfg_data
);

    localparam int C      = COORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int E      = plc_pkg::NUM_EDGES;
    localparam int DW     = ((4*COORD_BITS+7)/8)*8;
    localparam int FLAG_W = $bits(plc_pkg::edge_flags_t);
    localparam int SIDE_W = FLAG_W + 2*(C+1) + 2*C;
    localparam int RW     = 1 + E*C;
    localparam logic [F:0] T_ONE = (F+1)'(1) << F;

    // window registers
    logic [C-1:0] left_reg, right_reg, bottom_reg, top_reg;

    // stall control
    logic adv;

    // setup stage outputs
    logic                 su_valid;
    logic [E-1:0][C-1:0]  su_pmag, su_qmag;
    plc_pkg::edge_flags_t su_flags;
    logic [C-1:0]         su_sx, su_sy;
    logic signed [C:0]    su_dx, su_dy;

    // divider outputs
    logic                 dv_valid;
    logic [E-1:0][F:0]    dv_quo;
    logic [E-1:0]         dv_over;
    logic [SIDE_W-1:0]    dv_side;
    plc_pkg::edge_flags_t dv_flags;
    logic [C-1:0]         dv_sx, dv_sy;
    logic signed [C:0]    dv_dx, dv_dy;

    // parameter select stage
    logic                 t0_over;
    logic [F:0]           t0_next, t1_next;
    logic                 ok_next;
    logic                 sel_valid_reg, sel_ok_reg;
    logic [F:0]           t0_reg, t1_reg;
    logic [C-1:0]         sel_sx_reg, sel_sy_reg;
    logic signed [C:0]    sel_dx_reg, sel_dy_reg;

    // point stage outputs
    logic                 pt_valid, pt_visible;
    logic [E-1:0][C-1:0]  pt_coord;

    // output and skid registers
    logic                 out_valid_reg, skid_valid_reg;
    logic [RW-1:0]        out_data_reg, skid_data_reg;
    logic                 out_free;

    // configuration writes, always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            right_reg  <= '1;
            bottom_reg <= '0;
            top_reg    <= '1;
        end else if (cfg_valid) begin
            case (cfg_index)
                plc_pkg::REG_WINDOW_LEFT:   left_reg   <= cfg_data;
                plc_pkg::REG_WINDOW_RIGHT:  right_reg  <= cfg_data;
                plc_pkg::REG_WINDOW_BOTTOM: bottom_reg <= cfg_data;
                plc_pkg::REG_WINDOW_TOP:    top_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline moves while the skid register is empty
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    plc_edge_setup #(
        .COORD_BITS(C)
    ) u_setup (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (s_tvalid),
        .start_x      (s_tdata[0*C +: C]),
        .start_y      (s_tdata[1*C +: C]),
        .end_x        (s_tdata[2*C +: C]),
        .end_y        (s_tdata[3*C +: C]),
        .window_left  (left_reg),
        .window_right (right_reg),
        .window_bottom(bottom_reg),
        .window_top   (top_reg),
        .out_valid    (su_valid),
        .p_mag        (su_pmag),
        .q_mag        (su_qmag),
        .flags        (su_flags),
        .sx           (su_sx),
        .sy           (su_sy),
        .dx           (su_dx),
        .dy           (su_dy)
    );

    plc_div_pipe #(
        .COORD_BITS(C),
        .FRAC_BITS (F),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (su_valid),
        .in_num   (su_qmag),
        .in_den   (su_pmag),
        .in_side  ({su_flags, su_dy, su_dx, su_sy, su_sx}),
        .out_valid(dv_valid),
        .out_quo  (dv_quo),
        .out_over (dv_over),
        .out_side (dv_side)
    );

    assign {dv_flags, dv_dy, dv_dx, dv_sy, dv_sx} = dv_side;

    // entry parameter is the largest entry ratio, exit the smallest exit ratio
    always_comb begin
        t0_over = 1'b0;
        t0_next = '0;
        t1_next = T_ONE;
        for (int l = 0; l < E; l++) begin
            if (dv_flags.use_entry[l]) begin
                if (dv_over[l]) begin
                    t0_over = 1'b1;
                end else if (dv_quo[l] > t0_next) begin
                    t0_next = dv_quo[l];
                end
            end
            if (dv_flags.use_exit[l] && !dv_over[l] && (dv_quo[l] < t1_next)) begin
                t1_next = dv_quo[l];
            end
        end
        ok_next = !dv_flags.reject && !t0_over && (t0_next <= t1_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_valid_reg <= 1'b0;
        end else if (adv) begin
            sel_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sel_ok_reg <= ok_next;
            t0_reg     <= t0_next;
            t1_reg     <= t1_next;
            sel_sx_reg <= dv_sx;
            sel_sy_reg <= dv_sy;
            sel_dx_reg <= dv_dx;
            sel_dy_reg <= dv_dy;
        end
    end

    plc_point #(
        .COORD_BITS(C),
        .FRAC_BITS (F)
    ) u_point (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (sel_valid_reg),
        .in_ok      (sel_ok_reg),
        .t0         (t0_reg),
        .t1         (t1_reg),
        .sx         (sel_sx_reg),
        .sy         (sel_sy_reg),
        .dx         (sel_dx_reg),
        .dy         (sel_dy_reg),
        .out_valid  (pt_valid),
        .out_visible(pt_visible),
        .out_coord  (pt_coord)
    );

    // output register with skid register behind it
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= pt_valid;
            end
        end else if (pt_valid && adv) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : {pt_coord, pt_visible};
        end else if (adv) begin
            skid_data_reg <= {pt_coord, pt_visible};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg[0];
    assign m_tdata  = DW'(out_data_reg[RW-1:1]);

endmodule

// ===== src/plc_checker.sv =====
// ============================================================================
// plc_port_checks
// Port-level checks on the line clipper, attached to every instance.
// ============================================================================
module plc_port_checks #(
    parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = plc_pkg::FRAC_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [plc_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [COORD_BITS-1:0]         cfg_data
);

    localparam int DW = ((4*COORD_BITS+7)/8)*8;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // rejected segments carry zero coordinates
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == DW'(0))
        else $error("rejected item with non-zero coordinates");

    // input backpressure only while a result is waiting
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // nothing comes out just after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind parametric_line_clipper plc_port_checks #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_plc_port_checks (.*);
